// ===== rtl/core/sar_pkg.sv =====
// Types and constants shared by the scroll and address unit.
// Holds the item kind codes, CPU register numbers, state and result structs.
// No dependencies.
package sar_pkg;

  typedef enum logic [2:0] {
    KIND_BUS_WRITE = 3'd0,
    KIND_BUS_READ  = 3'd1,
    KIND_STEP_X    = 3'd2,
    KIND_STEP_Y    = 3'd3,
    KIND_COPY_H    = 3'd4,
    KIND_COPY_V    = 3'd5
  } kind_t;

  // CPU register numbers
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  localparam logic [2:0]  FINE_Y_LAST    = 3'd7;
  localparam logic [4:0]  COARSE_X_LAST  = 5'd31;
  localparam logic [4:0]  COARSE_Y_LAST  = 5'd29;
  localparam logic [4:0]  COARSE_Y_MAX   = 5'd31;
  localparam logic [14:0] ROW_STRIDE     = 15'd32;
  localparam logic [14:0] COLUMN_STRIDE  = 15'd1;

  // Address layout: [4:0] coarse X, [9:5] coarse Y, [10] nametable X,
  // [11] nametable Y, [14:12] fine Y.
  typedef struct packed {
    logic [14:0] current_addr;
    logic [14:0] temp_addr;
    logic [2:0]  fine_x;
    logic        write_toggle;
    logic        increment_by_row;
    logic [1:0]  render_enables;
  } scroll_state_t;

  typedef struct packed {
    logic        access_valid;
    logic        access_is_write;
    logic [13:0] access_address;
    logic [7:0]  access_data;
    logic [14:0] current_address;
    logic [2:0]  fine_scroll_x;
  } result_t;

endpackage

// ===== rtl/core/sar_step.sv =====
// Next-state and result logic for one item of the scroll and address unit.
// Purely combinational; depends on sar_pkg.
module sar_step
  import sar_pkg::*;
(
  input  scroll_state_t state,
  input  logic [2:0]    kind,
  input  logic [2:0]    reg_index,
  input  logic [7:0]    data,
  output scroll_state_t state_next,
  output result_t       result
);

  logic        rendering;
  logic [14:0] port_addr;
  logic [14:0] step_x_addr;
  logic [14:0] step_y_addr;
  logic [4:0]  tile_row;

  assign rendering = |state.render_enables;
  assign port_addr = state.current_addr +
                     (state.increment_by_row ? ROW_STRIDE : COLUMN_STRIDE);

  // Coarse X wraps into the neighboring nametable
  always_comb begin
    step_x_addr = state.current_addr;
    if (state.current_addr[4:0] == COARSE_X_LAST) begin
      step_x_addr[4:0] = 5'd0;
      step_x_addr[10]  = ~state.current_addr[10];
    end else begin
      step_x_addr[4:0] = state.current_addr[4:0] + 5'd1;
    end
  end

  // Fine Y first, then coarse Y; row 29 wraps with a nametable flip, row 31 wraps without one
  always_comb begin
    step_y_addr = state.current_addr;
    tile_row    = state.current_addr[9:5];
    if (state.current_addr[14:12] != FINE_Y_LAST) begin
      step_y_addr[14:12] = state.current_addr[14:12] + 3'd1;
    end else begin
      step_y_addr[14:12] = 3'd0;
      if (tile_row == COARSE_Y_LAST) begin
        step_y_addr[9:5] = 5'd0;
        step_y_addr[11]  = ~state.current_addr[11];
      end else if (tile_row == COARSE_Y_MAX) begin
        step_y_addr[9:5] = 5'd0;
      end else begin
        step_y_addr[9:5] = tile_row + 5'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    result     = '0;
    case (kind)
      KIND_BUS_WRITE: begin
        case (reg_index)
          REG_CTRL: begin
            state_next.increment_by_row = data[2];
            state_next.temp_addr[11:10] = data[1:0];
          end
          REG_MASK: begin
            state_next.render_enables = data[4:3];
          end
          REG_SCROLL: begin
            if (!state.write_toggle) begin
              state_next.fine_x         = data[2:0];
              state_next.temp_addr[4:0] = data[7:3];
              state_next.write_toggle   = 1'b1;
            end else begin
              state_next.temp_addr[14:12] = data[2:0];
              state_next.temp_addr[9:5]   = data[7:3];
              state_next.write_toggle     = 1'b0;
            end
          end
          REG_ADDR: begin
            if (!state.write_toggle) begin
              state_next.temp_addr[14]   = 1'b0;
              state_next.temp_addr[13:8] = data[5:0];
              state_next.write_toggle    = 1'b1;
            end else begin
              state_next.temp_addr[7:0] = data;
              state_next.current_addr   = {state.temp_addr[14:8], data};
              state_next.write_toggle   = 1'b0;
            end
          end
          REG_DATA: begin
            result.access_valid     = 1'b1;
            result.access_is_write  = 1'b1;
            result.access_address   = state.current_addr[13:0];
            result.access_data      = data;
            state_next.current_addr = port_addr;
          end
          default: begin
          end
        endcase
      end
      KIND_BUS_READ: begin
        if (reg_index == REG_STATUS) begin
          state_next.write_toggle = 1'b0;
        end else if (reg_index == REG_DATA) begin
          result.access_valid     = 1'b1;
          result.access_address   = state.current_addr[13:0];
          state_next.current_addr = port_addr;
        end
      end
      KIND_STEP_X: begin
        if (rendering) state_next.current_addr = step_x_addr;
      end
      KIND_STEP_Y: begin
        if (rendering) state_next.current_addr = step_y_addr;
      end
      KIND_COPY_H: begin
        if (rendering) begin
          state_next.current_addr[10]  = state.temp_addr[10];
          state_next.current_addr[4:0] = state.temp_addr[4:0];
        end
      end
      KIND_COPY_V: begin
        if (rendering) begin
          state_next.current_addr[14:11] = state.temp_addr[14:11];
          state_next.current_addr[9:5]   = state.temp_addr[9:5];
        end
      end
      default: begin
      end
    endcase
    result.current_address = state_next.current_addr;
    result.fine_scroll_x   = state_next.fine_x;
  end

endmodule

// ===== rtl/core/scroll_address_register_unit.sv =====
// Scroll and address unit of a tile display controller. Each item is a CPU
// register access or a render timing event; each gives exactly one result
// with the current address, fine X and any video memory access made through
// the data port. The unit takes one item per clock while not stalled: an item
// goes into the input register, then the scroll state and result register
// update as it advances, which waits while a held result is stalled. The
// rate is set by the combinational next-state logic in sar_step, which
// closes the loop on the scroll state. The unit keeps accepting while a
// result waits, until both the input and result registers are full.
// Depends on sar_pkg and sar_step.
module scroll_address_register_unit
  import sar_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [2:0]  reg_index,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        access_valid,
  output logic        access_is_write,
  output logic [13:0] access_address,
  output logic [7:0]  access_data,
  output logic [14:0] current_address,
  output logic [2:0]  fine_scroll_x
);

  logic          s1_valid;
  logic [2:0]    s1_kind;
  logic [2:0]    s1_reg_index;
  logic [7:0]    s1_data;
  scroll_state_t state;
  scroll_state_t state_next;
  result_t       result_next;
  result_t       result;
  logic          advance;
  logic          accept;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  sar_step u_step (
    .state      (state),
    .kind       (s1_kind),
    .reg_index  (s1_reg_index),
    .data       (s1_data),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: load on accept and advance only
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind      <= kind;
      s1_reg_index <= reg_index;
      s1_data      <= data;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign access_valid    = result.access_valid;
  assign access_is_write = result.access_is_write;
  assign access_address  = result.access_address;
  assign access_data     = result.access_data;
  assign current_address = result.current_address;
  assign fine_scroll_x   = result.fine_scroll_x;

  // A held result always matches the live state: nothing advances past it
  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> current_address == state.current_addr)
    else $error("result current address differs from state");

  a_port_increment: assert property (@(posedge clk) disable iff (rst)
    out_valid && access_valid |->
      access_address == 14'(current_address -
        (state.increment_by_row ? ROW_STRIDE : COLUMN_STRIDE)))
    else $error("data port access address does not match increment");

  a_read_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && access_valid && !access_is_write |-> access_data == 8'd0)
    else $error("data port read carries write data");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a full pipeline");

endmodule
